// ===== rtl/core/rbcc_pkg.sv =====
// Shared types and constants for the comparison-count ranking block.
// No dependencies; imported by the top level and the ranking sequencer.
`timescale 1ns / 1ps
`default_nettype none

package rbcc_pkg;

    localparam int MAX_ITEMS_DEF = 64;
    localparam int VALUE_W       = 32;
    localparam int POS_W         = 6;
    localparam int RANK_W        = 7;

    typedef logic signed [VALUE_W-1:0] t_value;

    typedef struct packed {
        logic go;
        logic overflow;
    } t_run_req;

endpackage

`default_nettype wire

// ===== rtl/core/rank_by_comparison_count.sv =====
// Top level of the comparison-count ranking block: load control, value store
// and ranking sequencer. Depends on rbcc_pkg, rbcc_ram and rbcc_rank.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------------
//   in      | input     | i_in_valid / o_in_stall | i_value, i_last_in
//   out     | output    | o_out_valid/ i_out_stall| o_position, o_rank, o_overflow,
//           |           |                         | o_last_out
//
// A word without last_in is only stored; the ranking sequencer stays idle.
// A word with last_in and n stored values starts a run of n results; each result
// goes through the single read port of the store as a key read, a key capture
// and n compare reads, then waits in the output state while the output is stalled.
// o_in_stall is high for the whole run. Reset clears the count and overflow flag;
// the store is not cleared, only entries below the count are read.
`timescale 1ns / 1ps
`default_nettype none

module rank_by_comparison_count #(
    parameter int MAX_ITEMS = rbcc_pkg::MAX_ITEMS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire rbcc_pkg::t_value            i_value,
    input  wire logic                        i_last_in,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [rbcc_pkg::POS_W-1:0]       o_position,
    output logic [rbcc_pkg::RANK_W-1:0]      o_rank,
    output logic                             o_overflow,
    output logic                             o_last_out
);
    import rbcc_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic          accept;
    logic          room;
    logic          busy;
    logic [AW-1:0] rd_addr;
    t_value        rd_data;
    t_run_req      req;
    logic [CW-1:0] run_count;

    assign o_in_stall = busy;
    assign accept     = i_in_valid && !busy;
    assign room       = (r_count < CW'(MAX_ITEMS));
    assign run_count  = r_count + CW'(room);

    assign req.go       = accept && i_last_in;
    assign req.overflow = r_ovf || !room;

    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        if (accept) begin
            if (i_last_in) begin
                n_count = '0;
                n_ovf   = 1'b0;
            end else begin
                n_count = run_count;
                n_ovf   = r_ovf || !room;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    rbcc_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (accept && room),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (i_value),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    rbcc_rank #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_rank (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .i_req_count (run_count),
        .o_busy      (busy),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_position  (o_position),
        .o_rank      (o_rank),
        .o_overflow  (o_overflow),
        .o_last_out  (o_last_out)
    );

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ITEMS))
        else $error("element count beyond capacity");

    a_ovf_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_count == CW'(MAX_ITEMS)))
        else $error("overflow flag set with room left");

    a_idle_after_reset_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_count == '0) && !r_ovf)
        else $error("list not cleared during ranking");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/rbcc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rbcc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/rbcc_rank.sv =====
// Ranking sequencer: walks the value store once per element, counts larger values
// and drives the result register. Depends on rbcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbcc_rank #(
    parameter int MAX_ITEMS = rbcc_pkg::MAX_ITEMS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire rbcc_pkg::t_run_req               i_req,
    input  wire logic [$clog2(MAX_ITEMS+1)-1:0]   i_req_count,
    output logic                                  o_busy,
    output logic      [$clog2(MAX_ITEMS)-1:0]     o_rd_addr,
    input  wire rbcc_pkg::t_value                 i_rd_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic      [rbcc_pkg::POS_W-1:0]       o_position,
    output logic      [rbcc_pkg::RANK_W-1:0]      o_rank,
    output logic                                  o_overflow,
    output logic                                  o_last_out
);
    import rbcc_pkg::*;

    localparam int AW   = $clog2(MAX_ITEMS);
    localparam int CW   = $clog2(MAX_ITEMS + 1);
    localparam int RW   = (CW > RANK_W) ? CW : RANK_W;
    localparam int PW   = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_KEY,
        S_KWAIT,
        S_SCAN,
        S_OUT
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_n, n_n;
    logic [CW-1:0]   r_i, n_i;
    logic [CW-1:0]   r_j, n_j;
    logic [CW-1:0]   r_greater, n_greater;
    t_value          r_key, n_key;
    logic            r_ovf, n_ovf;
    logic            r_out_valid, n_out_valid;
    logic [POS_W-1:0]  r_position, n_position;
    logic [RANK_W-1:0] r_rank, n_rank;
    logic            r_last, n_last;

    logic            gt;
    logic [CW-1:0]   greater_sum;
    logic [RW-1:0]   rank_ext;
    logic [PW-1:0]   pos_ext;

    assign gt          = (i_rd_data > r_key);
    assign greater_sum = r_greater + CW'(gt);
    assign rank_ext    = RW'(r_n) - RW'(greater_sum);
    assign pos_ext     = PW'(r_i);

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_i         = r_i;
        n_j         = r_j;
        n_greater   = r_greater;
        n_key       = r_key;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid;
        n_position  = r_position;
        n_rank      = r_rank;
        n_last      = r_last;
        o_rd_addr   = r_i[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_req.go) begin
                    n_n     = i_req_count;
                    n_ovf   = i_req.overflow;
                    n_i     = '0;
                    n_state = S_KEY;
                end
            end
            S_KEY: begin
                o_rd_addr = r_i[AW-1:0];
                n_state   = S_KWAIT;
            end
            S_KWAIT: begin
                o_rd_addr = '0;
                n_key     = i_rd_data;
                n_j       = CW'(1);
                n_greater = '0;
                n_state   = S_SCAN;
            end
            S_SCAN: begin
                o_rd_addr = r_j[AW-1:0];
                n_greater = greater_sum;
                if (r_j == r_n) begin
                    n_position  = pos_ext[POS_W-1:0];
                    n_rank      = rank_ext[RANK_W-1:0];
                    n_last      = (r_i + CW'(1) == r_n);
                    n_out_valid = 1'b1;
                    n_state     = S_OUT;
                end else begin
                    n_j = r_j + CW'(1);
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i     = r_i + CW'(1);
                        n_state = S_KEY;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_n        <= n_n;
        r_i        <= n_i;
        r_j        <= n_j;
        r_greater  <= n_greater;
        r_key      <= n_key;
        r_ovf      <= n_ovf;
        r_position <= n_position;
        r_rank     <= n_rank;
        r_last     <= n_last;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_position  = r_position;
    assign o_rank      = r_rank;
    assign o_overflow  = r_ovf;
    assign o_last_out  = r_last;

`ifndef NO_ASSERTIONS
    a_go_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.go |-> (r_state == S_IDLE))
        else $error("run request while ranking");

    a_valid_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == S_OUT))
        else $error("result valid outside output state");

    a_greater_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_greater < r_n) && (r_j <= r_n) && (r_i < r_n))
        else $error("scan counters out of range");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_last && !i_out_stall) |=> (r_state == S_IDLE))
        else $error("run did not end after final word");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_rank_by_comparison_count.sv =====
// Testbench for rank_by_comparison_count: loads lists of signed values and checks every
// rank word against a rank predictor. Depends on rbcc_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_rank_by_comparison_count;
    import rbcc_pkg::*;

    localparam int CAPACITY = MAX_ITEMS_DEF;

    typedef struct packed {
        t_value value;
        logic   last;
        logic   drain;
    } load_word_t;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [RANK_W-1:0] rank;
        logic              overflow;
        logic              last_out;
    } rank_word_t;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    t_value            i_value     = '0;
    logic              i_last_in   = 1'b0;
    logic              i_out_stall = 1'b0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic [POS_W-1:0]  o_position;
    logic [RANK_W-1:0] o_rank;
    logic              o_overflow;
    logic              o_last_out;

    load_word_t words_to_send[$];
    rank_word_t expected_ranks[$];

    t_value held_values[CAPACITY];
    int     held_count   = 0;
    logic   held_spilled = 1'b0;

    logic in_taken        = 1'b0;
    int   error_count     = 0;
    int   words_taken     = 0;
    int   ranks_checked   = 0;
    int   lists_ranked    = 0;
    int   overflow_ranks  = 0;

    wire sender_calm   = (words_taken >= 150) && (words_taken < 230);
    wire receiver_calm = (ranks_checked >= 120) && (ranks_checked < 260);

    rank_by_comparison_count u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_value     (i_value),
        .i_last_in   (i_last_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_position  (o_position),
        .o_rank      (o_rank),
        .o_overflow  (o_overflow),
        .o_last_out  (o_last_out)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic absorb_word(input t_value value, input logic last);
        int         greater;
        rank_word_t want;
        if (held_count < CAPACITY) begin
            held_values[held_count] = value;
            held_count++;
        end else begin
            held_spilled = 1'b1;
        end
        if (last) begin
            for (int i = 0; i < held_count; i++) begin
                greater = 0;
                for (int j = 0; j < held_count; j++) begin
                    if (held_values[j] > held_values[i]) greater++;
                end
                want.position = POS_W'(i);
                want.rank     = RANK_W'(held_count - greater);
                want.overflow = held_spilled;
                want.last_out = (i == held_count - 1);
                expected_ranks.push_back(want);
            end
            held_count   = 0;
            held_spilled = 1'b0;
        end
    endtask

    function automatic t_value pick_value(input int mode);
        int m;
        m = (mode == 3) ? $urandom_range(0, 2) : mode;
        case (m)
            0: return t_value'($urandom);
            1: return t_value'($urandom_range(0, 8)) - 32'sd4;
            default: begin
                case ($urandom_range(0, 5))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7FFF_FFFF;
                    2: return 32'sh8000_0001;
                    3: return 32'sh7FFF_FFFE;
                    4: return -32'sd1;
                    default: return 32'sd0;
                endcase
            end
        endcase
    endfunction

    task automatic push_word(input t_value value, input logic last, input logic drain);
        load_word_t w;
        w.value = value;
        w.last  = last;
        w.drain = drain;
        words_to_send.push_back(w);
    endtask

    task automatic queue_list(input int len, input int mode, input logic drain);
        for (int k = 0; k < len; k++) begin
            push_word(pick_value(mode), k == len - 1, drain && k == 0);
        end
    endtask

    // Offer a word only once the previous one has gone; hold a drain word until all ranks are in.
    always @(negedge i_clk) begin : drive_words
        load_word_t w;
        logic       offer;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            offer = (words_to_send.size() != 0) && (sender_calm || $urandom_range(0, 99) >= 17);
            if (offer && words_to_send[0].drain && expected_ranks.size() != 0) offer = 1'b0;
            if (offer) begin
                w = words_to_send.pop_front();
                i_value    <= w.value;
                i_last_in  <= w.last;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= i_rst_n && !receiver_calm && ($urandom_range(0, 99) < 17);
    end

    // Check the result side before taking the load side, so an old rank never meets a new list.
    always @(posedge i_clk) begin : watch_ports
        rank_word_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_ranks.size() == 0) begin
                flag_error($sformatf("unexpected rank word at position %0d", o_position));
            end else begin
                want = expected_ranks.pop_front();
                if (o_position !== want.position)
                    flag_error($sformatf("position got %0d want %0d", o_position, want.position));
                if (o_rank !== want.rank)
                    flag_error($sformatf("rank at %0d got %0d want %0d", want.position,
                                         o_rank, want.rank));
                if (o_overflow !== want.overflow)
                    flag_error($sformatf("overflow at %0d got %b want %b", want.position,
                                         o_overflow, want.overflow));
                if (o_last_out !== want.last_out)
                    flag_error($sformatf("last_out at %0d got %b want %b", want.position,
                                         o_last_out, want.last_out));
            end
            ranks_checked++;
            if (o_last_out) lists_ranked++;
            if (o_overflow) overflow_ranks++;
        end
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            absorb_word(i_value, i_last_in);
            words_taken++;
        end
    end

    initial begin : run_lists
        int list_idx;
        int len;

        push_word(32'sh8000_0000, 1'b1, 1'b0);
        push_word(32'sh7FFF_FFFF, 1'b0, 1'b0);
        push_word(32'sh8000_0000, 1'b0, 1'b0);
        push_word(32'sd0,         1'b0, 1'b0);
        push_word(-32'sd1,        1'b0, 1'b0);
        push_word(32'sd1,         1'b1, 1'b0);
        push_word(32'sd5,         1'b0, 1'b0);
        push_word(32'sd5,         1'b0, 1'b0);
        push_word(32'sd5,         1'b1, 1'b0);
        push_word(32'sh8000_0000, 1'b0, 1'b0);
        push_word(32'sh7FFF_FFFF, 1'b0, 1'b0);
        push_word(32'sh8000_0000, 1'b0, 1'b0);
        push_word(32'sh7FFF_FFFF, 1'b0, 1'b0);
        push_word(32'sd7,         1'b1, 1'b0);
        push_word(32'sd10,        1'b0, 1'b0);
        push_word(-32'sd10,       1'b1, 1'b0);
        push_word(32'sh7FFF_FFFF, 1'b0, 1'b0);
        push_word(32'sh7FFF_FFFF, 1'b1, 1'b0);
        push_word(32'sh5555_5555, 1'b0, 1'b0);
        push_word(32'shAAAA_AAAA, 1'b1, 1'b0);

        list_idx = 0;
        while (words_to_send.size() < 360) begin
            case (list_idx)
                3:       len = CAPACITY;
                9:       len = CAPACITY + 1;
                15:      len = CAPACITY + 6;
                default: len = $urandom_range(1, 12);
            endcase
            queue_list(len, $urandom_range(0, 3), (list_idx % 10 == 5) || (list_idx == 15));
            list_idx++;
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (words_to_send.size() != 0 || i_in_valid) @(posedge i_clk);
        while (expected_ranks.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (expected_ranks.size() != 0)
            flag_error($sformatf("%0d rank words never arrived", expected_ranks.size()));

        $display("Ranked %0d lists from %0d loaded words; %0d rank words checked,",
                 lists_ranked, words_taken, ranks_checked);
        $display("%0d of them from lists that overran the %0d-entry store.",
                 overflow_ranks, CAPACITY);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("Timed out with %0d rank words outstanding", expected_ranks.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/rbcc_pkg.sv
rtl/core/rbcc_ram.sv
rtl/core/rbcc_rank.sv
rtl/core/rank_by_comparison_count.sv
bench/tb_rank_by_comparison_count.sv
